>>> sv/smpf_pkg.sv
`timescale 1ns / 1ps

package smpf_pkg;

    localparam int MAX_COLUMNS = 512;
    localparam int MAX_ROWS    = 512;
    localparam int SCORE_BITS  = 16;
    localparam int THR_W       = 16;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int PEAK_POS_W  = 9;
    localparam int SIZE_W      = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int NUM_CAND    = 4;
    localparam int CAND_IDX_W  = $clog2(NUM_CAND);
    localparam int NUM_NB      = 8;
    localparam int LINE_W      = 2 * SCORE_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD   = 2'd0,
        CFG_MAP_COLUMNS = 2'd1,
        CFG_MAP_ROWS    = 2'd2
    } t_cfg_index;

    typedef logic signed [SCORE_BITS-1:0] t_score;
    typedef logic signed [THR_W-1:0]      t_thr;
    typedef logic [COL_W-1:0]             t_col;
    typedef logic [ROW_W-1:0]             t_row;
    typedef logic [LINE_W-1:0]            t_line;

    // Where the current cell sits relative to the map edges.
    typedef struct packed {
        logic c_ge1;
        logic c_ge2;
        logic r_ge1;
        logic r_ge2;
        logic c_last;
        logic r_last;
    } t_pos_flags;

    typedef struct packed {
        t_col   col;
        t_row   row;
        t_score value;
    } t_peak;

    // Strictly above the threshold and above every neighbour that is inside the map.
    function automatic logic peak_test(t_score ctr, logic [NUM_NB-1:0][SCORE_BITS-1:0] nb,
                                       logic [NUM_NB-1:0] nb_en, t_thr thr);
        logic ok;
        ok = (ctr > thr);
        for (int k = 0; k < NUM_NB; k++) begin
            if (nb_en[k] && !(ctr > $signed(nb[k]))) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic t_col last_col_of(logic [SIZE_W-1:0] size);
        t_col lim;
        if (size == '0) begin
            lim = '0;
        end else if (int'(size) > MAX_COLUMNS) begin
            lim = COL_W'(MAX_COLUMNS - 1);
        end else begin
            lim = COL_W'(size - 1'b1);
        end
        return lim;
    endfunction

    function automatic t_row last_row_of(logic [SIZE_W-1:0] size);
        t_row lim;
        if (size == '0) begin
            lim = '0;
        end else if (int'(size) > MAX_ROWS) begin
            lim = ROW_W'(MAX_ROWS - 1);
        end else begin
            lim = ROW_W'(size - 1'b1);
        end
        return lim;
    endfunction

endpackage

>>> sv/smpf_line_store.sv
`timescale 1ns / 1ps

module smpf_line_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  smpf_pkg::t_col     i_rd_addr,
    input  logic               i_wr_en,
    input  smpf_pkg::t_col     i_wr_addr,
    input  smpf_pkg::t_line    i_wr_data,
    output smpf_pkg::t_line    o_rd_data
);
    import smpf_pkg::*;

    // Each entry holds one column of the two most recent rows: upper half the newer row.
    t_line r_mem [MAX_COLUMNS];
    t_line r_rd_q;
    t_line r_fwd_data;
    logic  r_fwd_hit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
    end

    // A read of the entry being written in the same cycle takes the new data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rd_q;

endmodule

>>> sv/smpf_window.sv
`timescale 1ns / 1ps

module smpf_window (
    input  logic                                i_clk,
    input  logic                                i_go,
    input  smpf_pkg::t_score                    i_score,
    input  smpf_pkg::t_line                     i_col_data,
    input  smpf_pkg::t_col                      i_col,
    input  smpf_pkg::t_row                      i_row,
    input  smpf_pkg::t_pos_flags                i_flags,
    input  smpf_pkg::t_thr                      i_threshold,
    output smpf_pkg::t_line                     o_wr_data,
    output logic [smpf_pkg::NUM_CAND-1:0]       o_cand_hit,
    output smpf_pkg::t_peak [smpf_pkg::NUM_CAND-1:0] o_cand
);
    import smpf_pkg::*;

    // Index 0 is row r-2, 1 is row r-1, 2 is the current row r.
    t_score r_col_a [3];
    t_score r_col_b [3];
    t_score w_col_c [3];

    logic [NUM_CAND-1:0][NUM_NB-1:0][SCORE_BITS-1:0] w_nb;
    logic [NUM_CAND-1:0][NUM_NB-1:0]                 w_nb_en;
    t_score                                          w_ctr [NUM_CAND];
    logic                                            w_cand_en [NUM_CAND];
    t_col                                            w_col_m1;
    t_row                                            w_row_m1;
    logic                                            c1;
    logic                                            c2;
    logic                                            r1;
    logic                                            r2;

    assign w_col_c[0] = t_score'(i_col_data[SCORE_BITS-1:0]);
    assign w_col_c[1] = t_score'(i_col_data[LINE_W-1:SCORE_BITS]);
    assign w_col_c[2] = i_score;
    assign o_wr_data  = {i_score, i_col_data[LINE_W-1:SCORE_BITS]};

    assign w_col_m1 = i_col - COL_W'(1);
    assign w_row_m1 = i_row - ROW_W'(1);
    assign c1 = i_flags.c_ge1;
    assign c2 = i_flags.c_ge2;
    assign r1 = i_flags.r_ge1;
    assign r2 = i_flags.r_ge2;

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_col_a <= r_col_b;
            r_col_b <= w_col_c;
        end
    end

    always_comb begin
        // Cell (c-1, r-1): full window.
        w_ctr[0]     = r_col_b[1];
        w_cand_en[0] = r1 && c1;
        w_nb[0]      = {r_col_b[0], r_col_b[2], r_col_a[0], r_col_a[1],
                        r_col_a[2], w_col_c[0], w_col_c[1], w_col_c[2]};
        w_nb_en[0]   = {r2, 1'b1, c2 && r2, c2, c2, r2, 1'b1, 1'b1};

        // Cell (c, r-1) on the right edge: no column to its right.
        w_ctr[1]     = w_col_c[1];
        w_cand_en[1] = r1 && i_flags.c_last;
        w_nb[1]      = {w_col_c[0], w_col_c[2], r_col_b[0], r_col_b[1],
                        r_col_b[2], w_col_c[0], w_col_c[0], w_col_c[0]};
        w_nb_en[1]   = {r2, 1'b1, c1 && r2, c1, c1, 1'b0, 1'b0, 1'b0};

        // Cell (c-1, r) in the last row: no row below it.
        w_ctr[2]     = r_col_b[2];
        w_cand_en[2] = i_flags.r_last && c1;
        w_nb[2]      = {r_col_b[1], r_col_a[1], r_col_a[2], w_col_c[1],
                        w_col_c[2], w_col_c[2], w_col_c[2], w_col_c[2]};
        w_nb_en[2]   = {r1, c2 && r1, c2, r1, 1'b1, 1'b0, 1'b0, 1'b0};

        // Cell (c, r): the final cell of the map.
        w_ctr[3]     = w_col_c[2];
        w_cand_en[3] = i_flags.r_last && i_flags.c_last;
        w_nb[3]      = {w_col_c[1], r_col_b[1], r_col_b[2], w_col_c[1],
                        w_col_c[1], w_col_c[1], w_col_c[1], w_col_c[1]};
        w_nb_en[3]   = {r1, c1 && r1, c1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};
    end

    always_comb begin
        for (int k = 0; k < NUM_CAND; k++) begin
            o_cand_hit[k]   = w_cand_en[k] && peak_test(w_ctr[k], w_nb[k], w_nb_en[k],
                                                        i_threshold);
            o_cand[k].value = w_ctr[k];
        end
        o_cand[0].col = w_col_m1;
        o_cand[0].row = w_row_m1;
        o_cand[1].col = i_col;
        o_cand[1].row = w_row_m1;
        o_cand[2].col = w_col_m1;
        o_cand[2].row = i_row;
        o_cand[3].col = i_col;
        o_cand[3].row = i_row;
    end

endmodule

>>> sv/smpf_result_queue.sv
`timescale 1ns / 1ps

module smpf_result_queue (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_load,
    input  logic [smpf_pkg::NUM_CAND-1:0]            i_hit,
    input  smpf_pkg::t_peak [smpf_pkg::NUM_CAND-1:0] i_cand,
    output logic                                     o_can_load,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output smpf_pkg::t_peak                          o_peak,
    output logic                                     o_run_end
);
    import smpf_pkg::*;

    logic [NUM_CAND-1:0]  r_mask;
    logic [NUM_CAND-1:0]  w_rest;
    t_peak                r_cand [NUM_CAND];
    logic                 r_out_valid;
    t_peak                r_out_peak;
    logic                 r_out_end;
    logic [CAND_IDX_W-1:0] w_pick;
    logic                 w_out_adv;
    logic                 w_pop;

    // Results of one cell leave in raster order, lowest candidate first.
    always_comb begin
        w_pick = '0;
        for (int k = NUM_CAND - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                w_pick = CAND_IDX_W'(k);
            end
        end
    end

    assign w_rest     = r_mask & (r_mask - NUM_CAND'(1));
    assign w_out_adv  = !r_out_valid || i_out_ready;
    assign w_pop      = w_out_adv && (r_mask != '0);
    assign o_can_load = (r_mask == '0) || (w_pop && (w_rest == '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_mask <= i_hit;
            end else if (w_pop) begin
                r_mask <= w_rest;
            end
            if (w_out_adv) begin
                r_out_valid <= (r_mask != '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < NUM_CAND; k++) begin
                r_cand[k] <= i_cand[k];
            end
        end
        if (w_pop) begin
            r_out_peak <= r_cand[w_pick];
            r_out_end  <= (w_rest == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_peak      = r_out_peak;
    assign o_run_end   = r_out_end;

endmodule

>>> sv/score_map_peak_finder_top.sv
`timescale 1ns / 1ps

// Thresholded 3x3 local-maximum detector for a score map streamed in raster order.
// Input channel (i_in_valid / o_in_ready) takes one signed Q8.8 score per transfer.
// Output channel (o_out_valid / i_out_ready) gives each peak as column, row and score;
// o_run_end marks the last peak caused by one input transfer. Cells with no peak give
// nothing. A cell is decided when its lower-right neighbour arrives; right-edge and
// last-row cells are decided as soon as all their in-map neighbours have arrived.
// Configuration (i_cfg_valid / o_cfg_ready, always ready): index 0 threshold, 1 map
// columns, 2 map rows; write only while no item is in flight.
// A peak moves from the input stage register to the result stage and its output register.
// Throughput, while the receiver is ready: one cell per cycle while each cell decides at most
// one peak, and peaks leave one per cycle, so a cell's further peaks hold the result stage.
// The line store is a single 512 x 32 memory read and written once per cell, with
// forwarding for a one-column map.
// Reset clears the position counters and pipeline, sets threshold 0 and a 512 x 512
// map. If the receiver stalls, the result stage and then the input side fill and
// o_in_ready drops; nothing is lost.

module score_map_peak_finder_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [smpf_pkg::SCORE_BITS-1:0]      i_cell_score,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [smpf_pkg::PEAK_POS_W-1:0]      o_peak_column,
    output logic [smpf_pkg::PEAK_POS_W-1:0]      o_peak_row,
    output logic [smpf_pkg::SCORE_BITS-1:0]      o_peak_value,
    output logic                                 o_run_end,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [smpf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [smpf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import smpf_pkg::*;

    t_thr       r_threshold;
    t_col       r_last_col;
    t_row       r_last_row;
    t_col       r_col;
    t_row       r_row;

    logic       r_s1_valid;
    t_score     r_s1_score;
    t_col       r_s1_col;
    t_row       r_s1_row;
    t_pos_flags r_s1_flags;

    logic       w_wrap;
    t_col       w_c0;
    t_row       w_r0;
    t_pos_flags n_flags;
    logic       w_in_acc;
    logic       w_s1_go;
    logic       w_can_load;
    t_line      w_rd_data;
    t_line      w_wr_data;
    logic [NUM_CAND-1:0]   w_hit;
    t_peak [NUM_CAND-1:0]  w_cand;
    t_peak      w_peak;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
            r_last_col  <= COL_W'(MAX_COLUMNS - 1);
            r_last_row  <= ROW_W'(MAX_ROWS - 1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESHOLD: begin
                    r_threshold <= t_thr'(i_cfg_data);
                end
                CFG_MAP_COLUMNS: begin
                    r_last_col <= last_col_of(i_cfg_data[SIZE_W-1:0]);
                end
                CFG_MAP_ROWS: begin
                    r_last_row <= last_row_of(i_cfg_data[SIZE_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // A position outside a shrunk map starts a new map at the origin.
    assign w_wrap = (r_col > r_last_col) || (r_row > r_last_row);
    assign w_c0   = w_wrap ? '0 : r_col;
    assign w_r0   = w_wrap ? '0 : r_row;

    assign n_flags.c_ge1  = (w_c0 != '0);
    assign n_flags.c_ge2  = (w_c0 > COL_W'(1));
    assign n_flags.r_ge1  = (w_r0 != '0);
    assign n_flags.r_ge2  = (w_r0 > ROW_W'(1));
    assign n_flags.c_last = (w_c0 == r_last_col);
    assign n_flags.r_last = (w_r0 == r_last_row);

    assign w_s1_go    = r_s1_valid && w_can_load;
    assign o_in_ready = !r_s1_valid || w_can_load;
    assign w_in_acc   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_s1_valid <= 1'b1;
                if (n_flags.c_last) begin
                    r_col <= '0;
                    r_row <= n_flags.r_last ? '0 : w_r0 + ROW_W'(1);
                end else begin
                    r_col <= w_c0 + COL_W'(1);
                end
            end else if (w_s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_score <= t_score'(i_cell_score);
            r_s1_col   <= w_c0;
            r_s1_row   <= w_r0;
            r_s1_flags <= n_flags;
        end
    end

    smpf_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_in_acc),
        .i_rd_addr (w_c0),
        .i_wr_en   (w_s1_go),
        .i_wr_addr (r_s1_col),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    smpf_window u_window (
        .i_clk       (i_clk),
        .i_go        (w_s1_go),
        .i_score     (r_s1_score),
        .i_col_data  (w_rd_data),
        .i_col       (r_s1_col),
        .i_row       (r_s1_row),
        .i_flags     (r_s1_flags),
        .i_threshold (r_threshold),
        .o_wr_data   (w_wr_data),
        .o_cand_hit  (w_hit),
        .o_cand      (w_cand)
    );

    smpf_result_queue u_result_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_s1_go),
        .i_hit       (w_hit),
        .i_cand      (w_cand),
        .o_can_load  (w_can_load),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_peak      (w_peak),
        .o_run_end   (o_run_end)
    );

    assign o_peak_column = PEAK_POS_W'(w_peak.col);
    assign o_peak_row    = PEAK_POS_W'(w_peak.row);
    assign o_peak_value  = w_peak.value;

endmodule
